### rtl/bpln_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpln_pkg: shared types and constants of the band peak-level normaliser
// Field widths, register indexes, reset values and divider step count.
// ----------------------------------------------------------------------------
package bpln_pkg;

    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 11;
    localparam int BAND_W  = 4;
    localparam int BIN_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int CFG_DW  = 11;
    localparam int CFG_AW  = 1;
    localparam int STEP_W  = 4;

    localparam int BANDS_DEFAULT = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_SCALE = LEVEL_W'(1024);
    localparam logic [STEP_W-1:0]  DIV_STEPS   = STEP_W'(10);
    localparam logic [SIZE_W-1:0]  MAX_BINS    = SIZE_W'(64);

    localparam logic [SIZE_W-1:0]  BINS_RESET      = SIZE_W'(2);
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(30);
    localparam logic [DATA_W-1:0]  PEAK_RESET      = DATA_W'(1);

    typedef enum logic [CFG_AW-1:0] {
        CFG_BINS_PER_BAND   = 1'b0,
        CFG_LEVEL_THRESHOLD = 1'b1
    } cfg_index_t;

endpackage

### rtl/bpln_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpln_div: iterative level divider
// Restoring division giving floor(dividend * 1024 / divisor) for
// dividend <= divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpln_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bpln_pkg::DATA_W-1:0]    dividend,
    input  logic [bpln_pkg::DATA_W-1:0]    divisor,
    output logic                           done,
    output logic [bpln_pkg::LEVEL_W-1:0]   quotient
);
    import bpln_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   div_reg;
    logic [LEVEL_W-1:0]  quot_reg;

    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     diff;
    logic                ge;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (dividend >= divisor)
                begin
                    quot_reg <= LEVEL_SCALE;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rem_reg  <= dividend;
                    div_reg  <= divisor;
                    quot_reg <= '0;
                    cnt_reg  <= DIV_STEPS;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                quot_reg <= {quot_reg[LEVEL_W-2:0], ge};
                cnt_reg  <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/band_peak_level_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_peak_level_normalizer: per-band peak-hold level normaliser
// Groups power bins into bands, holds a peak per band, normalises each bin
// against it and emits the thresholded maximum level at each band end.
// ----------------------------------------------------------------------------
// Flow: one bin at a time; in_ready is high only in S_IDLE, and the shared
//   10-step divider works each bin. A bin whose power reaches the peak gets
//   full scale from the divider at once, without the division steps.
// Order: request taken in S_IDLE, peak updated in S_LOAD, quotient in S_DIV,
//   band result registered from S_EMIT once the output is free.
// Reset: all band peaks return to 1, counters and running level clear,
//   registers return to 2 bins per band and threshold 30.
module band_peak_level_normalizer #(
    parameter int BANDS = bpln_pkg::BANDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bpln_pkg::DATA_W-1:0]    bin_power,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bpln_pkg::BAND_W-1:0]    band_index,
    output logic [bpln_pkg::LEVEL_W-1:0]   band_level,
    output logic                           frame_last,
    input  logic                           cfg_write,
    input  logic [bpln_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [bpln_pkg::CFG_DW-1:0]    cfg_data
);
    import bpln_pkg::*;

    localparam int BAND_AW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [BAND_W:0] BANDS_LIM = (BAND_W + 1)'(BANDS);
    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BANDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [SIZE_W-1:0]   bins_per_band_reg;
    logic [LEVEL_W-1:0]  level_threshold_reg;
    logic [DATA_W-1:0]   peak_reg [BANDS];
    logic [DATA_W-1:0]   power_reg;
    logic [BIN_W-1:0]    bin_in_band_reg;
    logic [BAND_W-1:0]   band_counter_reg;
    logic [LEVEL_W-1:0]  running_level_reg;
    logic                out_valid_reg;
    logic [BAND_W-1:0]   band_index_reg;
    logic [LEVEL_W-1:0]  band_level_reg;
    logic                frame_last_reg;

    logic [DATA_W-1:0]   peak_old;
    logic [DATA_W-1:0]   peak_new;
    logic                div_start;
    logic                div_done;
    logic [LEVEL_W-1:0]  div_quot;
    logic [LEVEL_W-1:0]  level_max;
    logic [SIZE_W-1:0]   eff_size;
    logic                band_end;
    logic [BAND_W:0]     band_inc;
    logic                out_free;

    assign peak_old  = peak_reg[band_counter_reg[BAND_AW-1:0]];
    assign peak_new  = (power_reg > peak_old) ? power_reg : peak_old;
    assign div_start = (state_reg == S_LOAD);
    assign level_max = (div_quot > running_level_reg) ? div_quot : running_level_reg;
    assign eff_size  = (bins_per_band_reg == '0) ? SIZE_W'(1) :
                       (bins_per_band_reg > MAX_BINS) ? MAX_BINS : bins_per_band_reg;
    assign band_end  = ({1'b0, bin_in_band_reg} + SIZE_W'(1)) >= eff_size;
    assign band_inc  = {1'b0, band_counter_reg} + (BAND_W + 1)'(1);
    assign out_free  = !out_valid_reg || out_ready;

    bpln_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (power_reg),
        .divisor  (peak_new),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_per_band_reg   <= BINS_RESET;
            level_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BINS_PER_BAND:   bins_per_band_reg   <= cfg_data[SIZE_W-1:0];
                CFG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data[LEVEL_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BANDS; k++)
            begin
                peak_reg[k] <= PEAK_RESET;
            end
        end
        else if (state_reg == S_LOAD)
        begin
            peak_reg[band_counter_reg[BAND_AW-1:0]] <= peak_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            power_reg         <= '0;
            bin_in_band_reg   <= '0;
            band_counter_reg  <= '0;
            running_level_reg <= '0;
            out_valid_reg     <= 1'b0;
            band_index_reg    <= '0;
            band_level_reg    <= '0;
            frame_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        power_reg <= bin_power;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        running_level_reg <= level_max;
                        if (band_end)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            bin_in_band_reg <= bin_in_band_reg + BIN_W'(1);
                            state_reg       <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        band_index_reg    <= band_counter_reg;
                        band_level_reg    <= (running_level_reg > level_threshold_reg) ?
                                             running_level_reg : '0;
                        frame_last_reg    <= (band_counter_reg == BAND_LAST);
                        bin_in_band_reg   <= '0;
                        running_level_reg <= '0;
                        band_counter_reg  <= (band_inc >= BANDS_LIM) ? '0 :
                                             band_inc[BAND_W-1:0];
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign band_index = band_index_reg;
    assign band_level = band_level_reg;
    assign frame_last = frame_last_reg;

endmodule

### rtl/bpln_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpln_chk: port checker for the band peak-level normaliser
// Watches requests and results on the top-level ports.
// ----------------------------------------------------------------------------
module bpln_chk #(
    parameter int BANDS = bpln_pkg::BANDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [bpln_pkg::BAND_W-1:0]    band_index,
    input  logic [bpln_pkg::LEVEL_W-1:0]   band_level,
    input  logic                           frame_last
);
    import bpln_pkg::*;

    localparam logic [BAND_W:0] BANDS_LIM = (BAND_W + 1)'(BANDS);
    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BANDS - 1);

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous bin still in work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(band_index)
            && $stable(band_level) && $stable(frame_last))
        else $error("stalled result changed or dropped");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> band_level <= LEVEL_SCALE)
        else $error("band level above full scale");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, band_index} < BANDS_LIM)
        else $error("band index out of range");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_last == (band_index == BAND_LAST))
        else $error("frame end flag disagrees with band index");

endmodule

bind band_peak_level_normalizer bpln_chk #(.BANDS(BANDS)) u_bpln_chk (.*);

### verif/tb_band_peak_level_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_band_peak_level_normalizer: self-checking bench of the band normaliser
// Feeds directed and random power bins under changing band sizes and
// thresholds. A scoreboard tracks the band peaks and predicts each band
// result. Every result is checked field by field, in order, while in most
// random phases one or both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_band_peak_level_normalizer;

    import bpln_pkg::*;

    localparam int NUM_BANDS     = BANDS_DEFAULT;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_BINS    = 125;
    localparam int MAX_PRINTED   = 50;

    typedef struct packed {
        logic [BAND_W-1:0]  band_index;
        logic [LEVEL_W-1:0] band_level;
        logic               frame_last;
    } band_result_t;

    class band_level_scoreboard;
        logic [DATA_W-1:0]  peak_hold [BANDS_DEFAULT];
        int unsigned        bins_taken;
        int unsigned        band_now;
        logic [LEVEL_W-1:0] max_level;
        logic [SIZE_W-1:0]  size_reg;
        logic [LEVEL_W-1:0] thr_reg;
        band_result_t       awaited [$];
        int unsigned        errors;

        function new();
            foreach (peak_hold[k])
                peak_hold[k] = PEAK_RESET;
            bins_taken = 0;
            band_now   = 0;
            max_level  = '0;
            size_reg   = BINS_RESET;
            thr_reg    = THRESHOLD_RESET;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DW-1:0] value);
            if (idx == CFG_BINS_PER_BAND)
                size_reg = value[SIZE_W-1:0];
            else
                thr_reg = value[LEVEL_W-1:0];
        endfunction

        function logic [DATA_W-1:0] current_peak();
            return peak_hold[band_now];
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_bin(logic [DATA_W-1:0] power);
            logic [DATA_W-1:0]  pk;
            logic [63:0]        quot;
            logic [LEVEL_W-1:0] lvl;
            int unsigned        b;
            int unsigned        eff;
            band_result_t       res;
            b = (band_now >= NUM_BANDS) ? 0 : band_now;
            pk = peak_hold[b];
            if (power > pk)
                pk = power;
            if (pk == '0)
                pk = DATA_W'(1);
            peak_hold[b] = pk;
            quot = ({32'd0, power} * 64'd1024) / {32'd0, pk};
            if (quot > 64'd1024)
                quot = 64'd1024;
            lvl = quot[LEVEL_W-1:0];
            if (lvl > max_level)
                max_level = lvl;
            if (size_reg == '0)
                eff = 1;
            else if (size_reg > MAX_BINS)
                eff = 64;
            else
                eff = size_reg;
            if (bins_taken + 1 < eff)
            begin
                bins_taken = (bins_taken + 1) & 63;
                return;
            end
            res.band_index = b[BAND_W-1:0];
            res.band_level = (max_level > thr_reg) ? max_level : '0;
            res.frame_last = (b == NUM_BANDS - 1);
            awaited.push_back(res);
            bins_taken = 0;
            max_level  = '0;
            band_now   = (b + 1 >= NUM_BANDS) ? 0 : b + 1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [BAND_W-1:0] idx, logic [LEVEL_W-1:0] lvl, logic last);
            band_result_t exp_res;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result band %0d level %0d", idx, lvl));
                return;
            end
            exp_res = awaited.pop_front();
            if (idx !== exp_res.band_index)
                report($sformatf("band_index %0d, want %0d", idx, exp_res.band_index));
            if (lvl !== exp_res.band_level)
                report($sformatf("band_level %0d, want %0d (band %0d)", lvl,
                                 exp_res.band_level, exp_res.band_index));
            if (last !== exp_res.frame_last)
                report($sformatf("frame_last %0b, want %0b (band %0d)", last,
                                 exp_res.frame_last, exp_res.band_index));
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [DATA_W-1:0]   bin_power = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BAND_W-1:0]   band_index;
    logic [LEVEL_W-1:0]  band_level;
    logic                frame_last;
    logic                cfg_write = 1'b0;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data  = '0;

    band_level_scoreboard sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct     = 0;
    int unsigned          hold_len      = 0;
    int unsigned          hold_left     = 0;
    int unsigned          quiet_cycles  = 0;

    band_peak_level_normalizer #(
        .BANDS(NUM_BANDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .bin_power  (bin_power),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .band_index (band_index),
        .band_level (band_level),
        .frame_last (frame_last),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // hold off for a long stretch on demand, else stall at random
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(band_index, band_level, frame_last);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request or result for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_bin(logic [DATA_W-1:0] power);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        bin_power <= power;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_bin(power);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DW-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_power();
        logic [DATA_W-1:0] pk;
        logic [63:0]       prod;
        int unsigned       kind;
        pk   = sb.current_peak();
        kind = $urandom_range(0, 9);
        case (kind)
            0: return '0;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 1023));
            3: return pk;
            4: return (pk > 32'hFFFF_FF00) ? pk : pk + 32'($urandom_range(1, 255));
            8: return (pk > 3) ? pk - 32'($urandom_range(0, 3)) : pk;
            9: return $urandom >> $urandom_range(0, 31);
            default:
            begin
                prod = {32'd0, pk} * 64'($urandom_range(0, 1024));
                return prod[41:10];
            end
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_size();
        int unsigned kind;
        kind = $urandom_range(0, 15);
        case (kind)
            0: return '0;
            1: return CFG_DW'(64);
            2: return CFG_DW'($urandom_range(65, 127));
            3: return CFG_DW'($urandom);
            default: return CFG_DW'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_threshold();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return '0;
            1: return CFG_DW'(1024);
            2: return 11'h7FF;
            3: return CFG_DW'($urandom_range(0, 1024));
            default: return CFG_DW'($urandom_range(0, 60));
        endcase
    endfunction

    initial
    begin
        int unsigned mode;
        int unsigned idle_mix  [4];
        int unsigned stall_mix [4];
        idle_mix  = '{0, 78, 0, 12};
        stall_mix = '{0, 0, 78, 12};
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: full-scale and zero powers
        send_bin(32'd0);
        send_bin(32'd1);
        send_bin(32'hFFFF_FFFF);
        send_bin(32'h7FFF_FFFF);
        // zero band size, zero threshold
        write_reg(CFG_LEVEL_THRESHOLD, '0);
        write_reg(CFG_BINS_PER_BAND, '0);
        send_bin(32'd0);
        send_bin(32'd3);
        // threshold at full scale, band size shrunk mid-band
        write_reg(CFG_BINS_PER_BAND, CFG_DW'(8));
        write_reg(CFG_LEVEL_THRESHOLD, CFG_DW'(1024));
        send_bin(32'd10);
        send_bin(32'd20);
        send_bin(32'd5);
        send_bin(32'd40);
        send_bin(32'd7);
        write_reg(CFG_BINS_PER_BAND, CFG_DW'(3));
        send_bin(32'd40);
        write_reg(CFG_LEVEL_THRESHOLD, 11'h7FF);
        write_reg(CFG_BINS_PER_BAND, CFG_DW'(1));
        send_bin(32'd1);
        // last bands of the frame, then wrap
        write_reg(CFG_LEVEL_THRESHOLD, CFG_DW'(1));
        send_bin(32'd0);
        send_bin(32'd1);
        send_bin(32'd2);
        send_bin(32'd3);
        send_bin(32'd9);
        in_valid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_reg(CFG_BINS_PER_BAND, pick_size());
            write_reg(CFG_LEVEL_THRESHOLD, pick_threshold());
            mode          = ph % 4;
            send_idle_pct = idle_mix[mode];
            stall_pct     = stall_mix[mode];
            if (ph == 4)
                hold_len = 400;
            for (int k = 0; k < PHASE_BINS; k++)
                send_bin(pick_power());
            in_valid <= 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
